// ----- rtl/core/rfo_pkg.sv -----
// rfo_pkg: shared types, constants and helper functions for the rectangle fill overlay.
// Used by rfo_fill and rect_fill_overlay; depends on nothing else.
`timescale 1ns / 1ps

package rfo_pkg;

  localparam int unsigned MAX_FRAME_DIM = 4096;
  localparam int unsigned POS_W         = 12;
  localparam int unsigned WIDTH_W       = 13;
  localparam int unsigned CH_W          = 8;
  localparam int unsigned COLOR_W       = 24;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 24;
  localparam int unsigned PIX_DATA_W    = 4 * CH_W;

  localparam logic [WIDTH_W-1:0] FRAME_WIDTH_RST = 13'd640;
  localparam logic [CH_W-1:0]    CH_MAX          = 8'd255;

  // x / 3 == (x * GRAY_RECIP) >> GRAY_SHIFT for every x below 2**16
  localparam int unsigned  GRAY_SHIFT = 17;
  localparam logic [16:0]  GRAY_RECIP = 17'd43691;

  typedef enum logic [1:0] {
    FMT_GRAY = 2'd0,
    FMT_RGB  = 2'd1,
    FMT_RGBA = 2'd2
  } fmt_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_RECT_X0      = 3'd1,
    CFG_RECT_Y0      = 3'd2,
    CFG_RECT_X1      = 3'd3,
    CFG_RECT_Y1      = 3'd4,
    CFG_FILL_COLOR   = 3'd5,
    CFG_ADD_MODE     = 3'd6,
    CFG_PIXEL_FORMAT = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] ch2;
    logic [CH_W-1:0] ch1;
    logic [CH_W-1:0] ch0;
  } pixel_t;

  typedef struct packed {
    logic [POS_W-1:0]   rect_x0;
    logic [POS_W-1:0]   rect_y0;
    logic [POS_W-1:0]   rect_x1;
    logic [POS_W-1:0]   rect_y1;
    logic [COLOR_W-1:0] fill_color;
    logic               add_mode;
    logic [1:0]         pixel_format;
  } rfo_cfg_t;

  function automatic logic [CH_W-1:0] sat_add8(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
    logic [CH_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CH_W] ? CH_MAX : sum[CH_W-1:0];
  endfunction

  function automatic logic [CH_W-1:0] gray_of(input logic [COLOR_W-1:0] color);
    logic [9:0]  sum;
    logic [26:0] prod;
    sum  = 10'(color[7:0]) + 10'(color[15:8]) + 10'(color[23:16]);
    prod = 27'(sum) * 27'(GRAY_RECIP);
    return prod[GRAY_SHIFT+CH_W-1:GRAY_SHIFT];
  endfunction

endpackage

// ----- rtl/core/rect_fill_overlay.sv -----
// rect_fill_overlay: top level of the rectangle fill overlay on a raster pixel stream.
// Depends on rfo_pkg and rfo_fill.
//
// Usage:
//   Pixels enter on the s_axis stream in raster order, one per request; tuser marks the
//   first pixel of a frame and forces column 0, row 0. Results leave on m_axis, one per
//   pixel, in the same order; tuser there flags a pixel that lay inside the rectangle.
//   Configuration registers are written through cfg_we_i / cfg_index_i / cfg_wdata_i, one
//   register per cycle; the user must write only while the stream is idle (not enforced).
// Pipeline and throughput:
//   Two register stages: an input stage that holds the pixel with its column and row,
//   and a result register after the fill logic, through which each pixel passes in that
//   order to m_axis; one pixel per clock is sustained while m_axis_tready stays high.
// Reset:
//   rst_ni clears both stages, the column and row counters, and loads the register
//   defaults (line width 640, empty rectangle, replace mode, three-channel format).
// Stall:
//   When m_axis_tready is low the result holds; the input stage takes one more pixel
//   if it is empty, then s_axis_tready drops until the result is taken.
`timescale 1ns / 1ps

module rect_fill_overlay import rfo_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // pixel input
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [PIX_DATA_W-1:0] s_axis_tdata,  // in_ch0, in_ch1, in_ch2, in_alpha
  input  logic                  s_axis_tuser,  // start_of_frame
  // pixel output
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [PIX_DATA_W-1:0] m_axis_tdata,  // out_ch0, out_ch1, out_ch2, out_alpha
  output logic                  m_axis_tuser   // inside_rect
);

  localparam logic [POS_W-1:0]   ROW_LAST = POS_W'(MAX_FRAME_DIM - 1);
  localparam logic [WIDTH_W-1:0] COL_WRAP = WIDTH_W'(MAX_FRAME_DIM);

  // configuration registers
  logic [WIDTH_W-1:0] frame_width_q;
  rfo_cfg_t           cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q      <= FRAME_WIDTH_RST;
      cfg_q.rect_x0      <= '0;
      cfg_q.rect_y0      <= '0;
      cfg_q.rect_x1      <= '0;
      cfg_q.rect_y1      <= '0;
      cfg_q.fill_color   <= '0;
      cfg_q.add_mode     <= 1'b0;
      cfg_q.pixel_format <= FMT_RGB;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  frame_width_q      <= cfg_wdata_i[WIDTH_W-1:0];
        CFG_RECT_X0:      cfg_q.rect_x0      <= cfg_wdata_i[POS_W-1:0];
        CFG_RECT_Y0:      cfg_q.rect_y0      <= cfg_wdata_i[POS_W-1:0];
        CFG_RECT_X1:      cfg_q.rect_x1      <= cfg_wdata_i[POS_W-1:0];
        CFG_RECT_Y1:      cfg_q.rect_y1      <= cfg_wdata_i[POS_W-1:0];
        CFG_FILL_COLOR:   cfg_q.fill_color   <= cfg_wdata_i[COLOR_W-1:0];
        CFG_ADD_MODE:     cfg_q.add_mode     <= cfg_wdata_i[0];
        CFG_PIXEL_FORMAT: cfg_q.pixel_format <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_valid_q, m_valid_q;
  logic out_free, in_acc;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // position tracking at input acceptance
  logic [POS_W-1:0]   column_pos_q, column_pos_d;
  logic [POS_W-1:0]   row_pos_q, row_pos_d;
  logic [POS_W-1:0]   cur_col, cur_row;
  logic [WIDTH_W-1:0] next_col;
  logic               col_wrap;

  assign cur_col  = s_axis_tuser ? '0 : column_pos_q;
  assign cur_row  = s_axis_tuser ? '0 : row_pos_q;
  assign next_col = {1'b0, cur_col} + WIDTH_W'(1);
  // a zero line width wraps every pixel, same as a width of one
  assign col_wrap = (next_col >= frame_width_q) || (next_col >= COL_WRAP);

  always_comb begin
    if (col_wrap) begin
      column_pos_d = '0;
      row_pos_d    = (cur_row == ROW_LAST) ? ROW_LAST : cur_row + POS_W'(1);
    end else begin
      column_pos_d = next_col[POS_W-1:0];
      row_pos_d    = cur_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_pos_q <= '0;
      row_pos_q    <= '0;
    end else if (in_acc) begin
      column_pos_q <= column_pos_d;
      row_pos_q    <= row_pos_d;
    end
  end

  // input stage
  pixel_t           s1_pix_q;
  logic [POS_W-1:0] s1_col_q, s1_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q.ch0   <= s_axis_tdata[7:0];
      s1_pix_q.ch1   <= s_axis_tdata[15:8];
      s1_pix_q.ch2   <= s_axis_tdata[23:16];
      s1_pix_q.alpha <= s_axis_tdata[31:24];
      s1_col_q       <= cur_col;
      s1_row_q       <= cur_row;
    end
  end

  // fill logic
  pixel_t fill_pix;
  logic   fill_inside;

  rfo_fill u_fill (
    .cfg_i    (cfg_q),
    .pix_i    (s1_pix_q),
    .col_i    (s1_col_q),
    .row_i    (s1_row_q),
    .pix_o    (fill_pix),
    .inside_o (fill_inside)
  );

  // result register
  pixel_t out_pix_q;
  logic   out_inside_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_free) begin
      m_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q) begin
      out_pix_q    <= fill_pix;
      out_inside_q <= fill_inside;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {out_pix_q.alpha, out_pix_q.ch2, out_pix_q.ch1, out_pix_q.ch0};
  assign m_axis_tuser  = out_inside_q;

  // both stages full and result stalled: no new request may be taken
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && m_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while both stages are full");

  // a frame start places the pixel at the origin
  a_sof_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser) |=> (s1_col_q == '0 && s1_row_q == '0))
    else $error("start of frame did not reset position");

  // the row counter saturates instead of wrapping
  a_row_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !s_axis_tuser && row_pos_q == ROW_LAST) |=> (row_pos_q == ROW_LAST))
    else $error("row counter wrapped");

  // a pixel leaving the input stage always lands in the result register
  a_stage_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_free) |=> m_valid_q)
    else $error("pixel lost between stages");

endmodule

// ----- rtl/core/rfo_fill.sv -----
// rfo_fill: per-pixel rectangle test and fill / saturating add, purely combinational.
// Depends on rfo_pkg for pixel and configuration types and the channel helpers.
`timescale 1ns / 1ps

module rfo_fill import rfo_pkg::*; (
  input  rfo_cfg_t         cfg_i,
  input  pixel_t           pix_i,
  input  logic [POS_W-1:0] col_i,
  input  logic [POS_W-1:0] row_i,
  output pixel_t           pix_o,
  output logic             inside_o
);

  logic [POS_W-1:0] x_lo, x_hi, y_lo, y_hi;
  logic [CH_W-1:0]  f0, f1, f2, gray;
  logic             in_rect;

  assign x_lo = (cfg_i.rect_x0 < cfg_i.rect_x1) ? cfg_i.rect_x0 : cfg_i.rect_x1;
  assign x_hi = (cfg_i.rect_x0 < cfg_i.rect_x1) ? cfg_i.rect_x1 : cfg_i.rect_x0;
  assign y_lo = (cfg_i.rect_y0 < cfg_i.rect_y1) ? cfg_i.rect_y0 : cfg_i.rect_y1;
  assign y_hi = (cfg_i.rect_y0 < cfg_i.rect_y1) ? cfg_i.rect_y1 : cfg_i.rect_y0;

  // upper corner is exclusive, so equal corners give an empty span
  assign in_rect = (col_i >= x_lo) && (col_i < x_hi) && (row_i >= y_lo) && (row_i < y_hi);

  assign f0   = cfg_i.fill_color[7:0];
  assign f1   = cfg_i.fill_color[15:8];
  assign f2   = cfg_i.fill_color[23:16];
  assign gray = gray_of(cfg_i.fill_color);

  always_comb begin
    pix_o = pix_i;
    case (cfg_i.pixel_format)
      FMT_GRAY: begin
        if (in_rect) begin
          pix_o.ch0 = cfg_i.add_mode ? sat_add8(pix_i.ch0, gray) : gray;
        end
        pix_o.ch1   = '0;
        pix_o.ch2   = '0;
        pix_o.alpha = '0;
      end
      FMT_RGB, FMT_RGBA: begin
        if (in_rect) begin
          pix_o.ch0   = cfg_i.add_mode ? sat_add8(pix_i.ch0, f0) : f0;
          pix_o.ch1   = cfg_i.add_mode ? sat_add8(pix_i.ch1, f1) : f1;
          pix_o.ch2   = cfg_i.add_mode ? sat_add8(pix_i.ch2, f2) : f2;
          pix_o.alpha = CH_MAX;
        end
        if (cfg_i.pixel_format == FMT_RGB) begin
          pix_o.alpha = '0;
        end
      end
      // reserved format code: pixel passes untouched
      default: pix_o = pix_i;
    endcase
  end

  assign inside_o = in_rect;

endmodule
